### rtl/cmr_pkg.sv
// cmr_pkg: shared constants, status codes and controller/datapath interface types
// for the CAN multiframe reassembler; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package cmr_pkg;

	localparam int SLOT_COUNT_DEF    = 8;
	localparam int MESSAGE_BYTES_DEF = 256;

	localparam int ID_W   = 29;
	localparam int LEN_W  = 4;
	localparam int DATA_W = 64;
	localparam int STAT_W = 2;
	localparam int MLEN_W = 9;
	localparam int WIDX_W = 5;

	localparam logic [STAT_W-1:0] STAT_WORD = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
	localparam logic [STAT_W-1:0] STAT_OVF  = 2'd2;

	typedef struct packed {
		logic load;
		logic scan;
		logic sel;
		logic chk;
		logic report;
		logic wr;
		logic fin;
		logic rd_clr;
		logic rd;
		logic push;
	} cmd_t;

	typedef struct packed {
		logic in_len_zero;
		logic scan_done;
		logic table_full;
		logic overflow;
		logic wr_done;
		logic fr_zero;
		logic total_zero;
		logic rd_done;
		logic emit_last;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

### rtl/cmr_ctrl.sv
// cmr_ctrl: sequencing state machine of the reassembler
// depends on cmr_pkg (cmd_t, sts_t)
`timescale 1ns / 1ps
`default_nettype none
module cmr_ctrl (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            in_valid,
	output logic           in_stall,
	input  cmr_pkg::sts_t  sts,
	output cmr_pkg::cmd_t  cmd
);
	import cmr_pkg::*;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_SCAN   = 4'd1;
	localparam logic [3:0] ST_SEL    = 4'd2;
	localparam logic [3:0] ST_CHK    = 4'd3;
	localparam logic [3:0] ST_EVAL   = 4'd4;
	localparam logic [3:0] ST_REPORT = 4'd5;
	localparam logic [3:0] ST_WR     = 4'd6;
	localparam logic [3:0] ST_FIN    = 4'd7;
	localparam logic [3:0] ST_RDST   = 4'd8;
	localparam logic [3:0] ST_RD     = 4'd9;
	localparam logic [3:0] ST_PUSH   = 4'd10;

	logic [3:0] state_q, state_d;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && !sts.in_len_zero) begin
					cmd.load = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) state_d = ST_SEL;
			end
			ST_SEL: begin
				cmd.sel = 1'b1;
				state_d = sts.table_full ? ST_REPORT : ST_CHK;
			end
			ST_CHK: begin
				cmd.chk = 1'b1;
				state_d = ST_EVAL;
			end
			ST_EVAL: begin
				state_d = sts.overflow ? ST_REPORT : ST_WR;
			end
			ST_REPORT: begin
				if (sts.out_free) begin
					cmd.report = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_WR: begin
				if (sts.wr_done) state_d = ST_FIN;
				else cmd.wr = 1'b1;
			end
			ST_FIN: begin
				cmd.fin = 1'b1;
				state_d = (!sts.fr_zero || sts.total_zero) ? ST_IDLE : ST_RDST;
			end
			ST_RDST: begin
				cmd.rd_clr = 1'b1;
				state_d = ST_RD;
			end
			ST_RD: begin
				if (sts.rd_done) state_d = ST_PUSH;
				else cmd.rd = 1'b1;
			end
			ST_PUSH: begin
				if (sts.out_free) begin
					cmd.push = 1'b1;
					state_d = sts.emit_last ? ST_IDLE : ST_RDST;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

endmodule
`default_nettype wire

### rtl/cmr_dpath.sv
// cmr_dpath: slot table, byte store, word assembly and output register
// depends on cmr_pkg (cmd_t, sts_t, widths, status codes)
`timescale 1ns / 1ps
`default_nettype none
module cmr_dpath #(
	parameter int SLOT_COUNT    = cmr_pkg::SLOT_COUNT_DEF,
	parameter int MESSAGE_BYTES = cmr_pkg::MESSAGE_BYTES_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  cmr_pkg::cmd_t                cmd,
	output cmr_pkg::sts_t                sts,
	input  wire [cmr_pkg::ID_W-1:0]      can_id,
	input  wire [cmr_pkg::LEN_W-1:0]     frame_length,
	input  wire [cmr_pkg::DATA_W-1:0]    frame_bytes,
	output logic                         out_valid,
	input  wire                          out_stall,
	output logic [cmr_pkg::ID_W-1:0]     msg_id,
	output logic [cmr_pkg::STAT_W-1:0]   status,
	output logic [cmr_pkg::MLEN_W-1:0]   message_length,
	output logic [cmr_pkg::WIDX_W-1:0]   word_index,
	output logic [cmr_pkg::DATA_W-1:0]   message_word,
	output logic                         last_word
);
	import cmr_pkg::*;

	localparam int SW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CW    = $clog2(MESSAGE_BYTES + 1);
	localparam int TOTAL = SLOT_COUNT * MESSAGE_BYTES;
	localparam int AW    = $clog2(TOTAL);
	localparam int PW    = CW + 4;

	// latched frame
	logic [ID_W-1:0] id_q;
	logic [2:0]      npay_q;
	logic            fr_zero_q;
	logic [55:0]     pay_q;

	// slot table
	logic [SLOT_COUNT-1:0] valid_q;
	logic [ID_W-1:0]       id_mem [SLOT_COUNT];
	logic [CW-1:0]         cnt_mem [SLOT_COUNT];

	// scan
	logic [SW:0]     scan_idx_q;
	logic            pend_s1;
	logic [SW-1:0]   idx_s1;
	logic [ID_W-1:0] id_rd_s1;
	logic            hit_q, free_q;
	logic [SW-1:0]   hit_idx_q, free_idx_q;

	// selected slot
	logic [SW-1:0] slot_q;
	logic          claim_q;
	logic          full_q;
	logic [CW-1:0] cnt_rd_q, cnt_q;
	logic [2:0]    k_q;

	// byte store and word assembly
	logic [7:0]    store [TOTAL];
	logic [CW-1:0] w_q;
	logic [3:0]    b_q;
	logic          rpend_s1, rin_s1;
	logic [2:0]    rb_s1;
	logic [7:0]    byte_rd_s1;
	logic [63:0]   word_q;

	logic          out_valid_q;

	logic [SW-1:0] slot_next;
	logic [CW:0]   total;
	logic [PW-1:0] rpos;
	logic          rin;
	logic [AW-1:0] raddr, waddr;
	logic [PW-1:0] next_end;

	assign slot_next = hit_q ? hit_idx_q : free_idx_q;
	assign total     = (CW+1)'(cnt_q) + (CW+1)'(npay_q);
	assign rpos      = PW'({w_q, 3'b000}) + PW'(b_q);
	assign rin       = rpos < PW'(cnt_q);
	assign raddr     = rin ? (AW'(slot_q) * AW'(MESSAGE_BYTES) + AW'(rpos)) : '0;
	assign waddr     = AW'(slot_q) * AW'(MESSAGE_BYTES) + AW'(cnt_q) + AW'(k_q);
	assign next_end  = PW'({w_q, 3'b000}) + PW'(8);

	assign sts.in_len_zero = (frame_length == '0);
	assign sts.scan_done   = (scan_idx_q == (SW+1)'(SLOT_COUNT)) && !pend_s1;
	assign sts.table_full  = !hit_q && !free_q;
	assign sts.overflow    = total > (CW+1)'(MESSAGE_BYTES);
	assign sts.wr_done     = (k_q == npay_q);
	assign sts.fr_zero     = fr_zero_q;
	assign sts.total_zero  = (total == '0);
	assign sts.rd_done     = (b_q == 4'd8) && !rpend_s1;
	assign sts.emit_last   = next_end >= PW'(cnt_q);
	assign sts.out_free    = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;

	// frame latch, scan, slot selection and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			scan_idx_q <= '0;
			pend_s1    <= 1'b0;
			hit_q      <= 1'b0;
			free_q     <= 1'b0;
			rpend_s1   <= 1'b0;
		end else begin
			if (cmd.load) begin
				scan_idx_q <= '0;
				pend_s1    <= 1'b0;
				hit_q      <= 1'b0;
				free_q     <= 1'b0;
			end
			if (cmd.scan) begin
				if (scan_idx_q != (SW+1)'(SLOT_COUNT)) begin
					pend_s1    <= 1'b1;
					scan_idx_q <= scan_idx_q + 1'b1;
				end else begin
					pend_s1 <= 1'b0;
				end
			end
			if (pend_s1) begin
				if (valid_q[idx_s1] && id_rd_s1 == id_q) hit_q <= 1'b1;
				if (!valid_q[idx_s1] && !free_q) free_q <= 1'b1;
			end
			if (cmd.sel && !hit_q && free_q) valid_q[free_idx_q] <= 1'b1;
			if (cmd.report && !full_q) valid_q[slot_q] <= 1'b0;
			if (cmd.fin && fr_zero_q) valid_q[slot_q] <= 1'b0;
			if (cmd.rd_clr) rpend_s1 <= 1'b0;
			if (cmd.rd) rpend_s1 <= (b_q != 4'd8);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			id_q      <= can_id;
			npay_q    <= (frame_length > 4'd8) ? 3'd7 : 3'(frame_length - 4'd1);
			fr_zero_q <= (frame_bytes[7:0] == 8'd0);
			pay_q     <= frame_bytes[63:8];
		end
		if (cmd.scan) idx_s1 <= scan_idx_q[SW-1:0];
		if (pend_s1) begin
			if (valid_q[idx_s1] && id_rd_s1 == id_q) hit_idx_q <= idx_s1;
			if (!valid_q[idx_s1] && !free_q) free_idx_q <= idx_s1;
		end
		if (cmd.sel) begin
			slot_q  <= slot_next;
			claim_q <= !hit_q;
			full_q  <= !hit_q && !free_q;
		end
		if (cmd.chk) begin
			cnt_q <= claim_q ? '0 : cnt_rd_q;
			k_q   <= '0;
		end
		if (cmd.wr) k_q <= k_q + 3'd1;
		if (cmd.fin) begin
			cnt_q <= CW'(total);
			w_q   <= '0;
		end
		if (cmd.rd_clr) begin
			b_q    <= '0;
			word_q <= '0;
		end
		if (cmd.rd && b_q != 4'd8) begin
			b_q    <= b_q + 4'd1;
			rb_s1  <= b_q[2:0];
			rin_s1 <= rin;
		end
		if (rpend_s1) word_q[rb_s1*8 +: 8] <= rin_s1 ? byte_rd_s1 : 8'd0;
		if (cmd.push) w_q <= w_q + 1'b1;
	end

	// slot identifier and byte count tables
	always_ff @(posedge clk) begin
		if (cmd.scan && scan_idx_q != (SW+1)'(SLOT_COUNT))
			id_rd_s1 <= id_mem[scan_idx_q[SW-1:0]];
		if (cmd.sel && !hit_q && free_q) id_mem[free_idx_q] <= id_q;
		if (cmd.sel) cnt_rd_q <= cnt_mem[slot_next];
		if (cmd.fin) cnt_mem[slot_q] <= CW'(total);
	end

	// payload byte store
	always_ff @(posedge clk) begin
		if (cmd.wr && k_q != npay_q) store[waddr] <= pay_q[k_q*8 +: 8];
		if (cmd.rd && b_q != 4'd8) byte_rd_s1 <= store[raddr];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.report || cmd.push) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.report) begin
			msg_id         <= id_q;
			status         <= full_q ? STAT_FULL : STAT_OVF;
			message_length <= '0;
			word_index     <= '0;
			message_word   <= '0;
			last_word      <= 1'b1;
		end
		if (cmd.push) begin
			msg_id         <= id_q;
			status         <= STAT_WORD;
			message_length <= MLEN_W'(cnt_q);
			word_index     <= WIDX_W'(w_q);
			message_word   <= word_q;
			last_word      <= sts.emit_last;
		end
	end

endmodule
`default_nettype wire

### rtl/can_multiframe_reassembler_unit.sv
// can_multiframe_reassembler_unit: top level of the CAN multiframe reassembler
// depends on cmr_pkg, cmr_ctrl, cmr_dpath
//
// Input channel (in_valid/in_stall) takes one CAN frame per transaction: can_id,
// frame_length, frame_bytes. Output channel (out_valid/out_stall) gives one result
// per transaction: a message word or a drop report, last_word on the final one.
// Frames are handled one at a time; in_stall is high while a frame is in work.
// A zero-length frame is taken and dropped without leaving the idle state.
// Other frames: slot lookup reads the slot table once per slot, then the length
// check runs and the append writes the payload bytes one at a time. A completing
// frame then emits ceil(n/8) words, each assembled from one byte store read per
// byte, gated by the output register.
// A result waits in the output register while out_stall is high; the block
// holds the next result in the matching wait state until the register is free.
// Reset clears all slot valid bits and the output valid bit; the byte store
// needs no clearing.
`timescale 1ns / 1ps
`default_nettype none
module can_multiframe_reassembler_unit #(
	parameter int SLOT_COUNT    = cmr_pkg::SLOT_COUNT_DEF,
	parameter int MESSAGE_BYTES = cmr_pkg::MESSAGE_BYTES_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_stall,
	input  wire [cmr_pkg::ID_W-1:0]      can_id,
	input  wire [cmr_pkg::LEN_W-1:0]     frame_length,
	input  wire [cmr_pkg::DATA_W-1:0]    frame_bytes,
	output logic                         out_valid,
	input  wire                          out_stall,
	output logic [cmr_pkg::ID_W-1:0]     msg_id,
	output logic [cmr_pkg::STAT_W-1:0]   status,
	output logic [cmr_pkg::MLEN_W-1:0]   message_length,
	output logic [cmr_pkg::WIDX_W-1:0]   word_index,
	output logic [cmr_pkg::DATA_W-1:0]   message_word,
	output logic                         last_word
);
	import cmr_pkg::*;

	cmd_t cmd;
	sts_t sts;

	cmr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	cmr_dpath #(
		.SLOT_COUNT    (SLOT_COUNT),
		.MESSAGE_BYTES (MESSAGE_BYTES)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.can_id         (can_id),
		.frame_length   (frame_length),
		.frame_bytes    (frame_bytes),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.msg_id         (msg_id),
		.status         (status),
		.message_length (message_length),
		.word_index     (word_index),
		.message_word   (message_word),
		.last_word      (last_word)
	);

endmodule
`default_nettype wire

### tb/sv/can_multiframe_reassembler_unit_test.sv
// can_multiframe_reassembler_unit_test: self-checking testbench for the CAN multiframe
// reassembler; a directed table and long messages, then random multi-frame traffic checked by a predictor
// depends on cmr_pkg and can_multiframe_reassembler_unit
`timescale 1ns / 1ps
module can_multiframe_reassembler_unit_test;
	import cmr_pkg::*;

	localparam int NSLOT = SLOT_COUNT_DEF;
	localparam int MBYTES = MESSAGE_BYTES_DEF;
	localparam int CYCLE_LIMIT = 10000000;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [STAT_W-1:0] stat;
		logic [MLEN_W-1:0] mlen;
		logic [WIDX_W-1:0] widx;
		logic [DATA_W-1:0] word;
		logic              last;
	} result_t;

	typedef struct {
		logic [ID_W-1:0]   id;
		logic [LEN_W-1:0]  len;
		logic [DATA_W-1:0] data;
		bit                fixed;
		result_t           res;
	} frame_row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [ID_W-1:0] can_id = '0;
	logic [LEN_W-1:0] frame_length = '0;
	logic [DATA_W-1:0] frame_bytes = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [ID_W-1:0] msg_id;
	logic [STAT_W-1:0] status;
	logic [MLEN_W-1:0] message_length;
	logic [WIDX_W-1:0] word_index;
	logic [DATA_W-1:0] message_word;
	logic last_word;

	can_multiframe_reassembler_unit u_top (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.can_id(can_id), .frame_length(frame_length), .frame_bytes(frame_bytes),
		.out_valid(out_valid), .out_stall(out_stall), .msg_id(msg_id), .status(status),
		.message_length(message_length), .word_index(word_index),
		.message_word(message_word), .last_word(last_word)
	);

	always #5 clk = ~clk;

	// predictor state
	bit              slot_used[NSLOT];
	logic [ID_W-1:0] slot_tag[NSLOT];
	int              slot_fill[NSLOT];
	logic [7:0]      slot_bytes[NSLOT][MBYTES];

	result_t pending_results[$];
	int errors = 0;
	int frames_sent = 0;
	int results_seen = 0;
	int drops_seen = 0;
	int stall_left = 0;
	longint cycles = 0;

	function automatic result_t mk(logic [ID_W-1:0] id, logic [STAT_W-1:0] st,
		int ml, int wi, logic [DATA_W-1:0] w, bit l);
		result_t r;
		r.id = id; r.stat = st; r.mlen = ml[MLEN_W-1:0]; r.widx = wi[WIDX_W-1:0];
		r.word = w; r.last = l;
		return r;
	endfunction

	task automatic reassemble_frame(input logic [ID_W-1:0] id, input logic [LEN_W-1:0] len_in,
		input logic [DATA_W-1:0] data);
		int len, npay, hit, fr, n, nw;
		logic [DATA_W-1:0] w;
		len = len_in;
		hit = -1;
		fr = -1;
		if (len == 0)
			return;
		if (len > 8)
			len = 8;
		npay = len - 1;
		for (int s = 0; s < NSLOT; s++) begin
			if (slot_used[s] && slot_tag[s] == id) begin
				hit = s;
				break;
			end
			if (!slot_used[s] && fr < 0)
				fr = s;
		end
		if (hit < 0) begin
			if (fr < 0) begin
				pending_results.push_back(mk(id, STAT_FULL, 0, 0, '0, 1'b1));
				return;
			end
			hit = fr;
			slot_used[hit] = 1;
			slot_tag[hit] = id;
			slot_fill[hit] = 0;
		end
		if (slot_fill[hit] + npay > MBYTES) begin
			slot_used[hit] = 0; slot_tag[hit] = '0; slot_fill[hit] = 0;
			pending_results.push_back(mk(id, STAT_OVF, 0, 0, '0, 1'b1));
			return;
		end
		for (int k = 0; k < npay; k++)
			slot_bytes[hit][slot_fill[hit] + k] = data[8*(k+1) +: 8];
		slot_fill[hit] += npay;
		if (data[7:0] != 8'd0)
			return;
		n = slot_fill[hit];
		slot_used[hit] = 0; slot_tag[hit] = '0; slot_fill[hit] = 0;
		nw = (n + 7) / 8;
		for (int wi = 0; wi < nw; wi++) begin
			w = '0;
			for (int k = 0; k < 8; k++)
				if (wi*8 + k < n)
					w[8*k +: 8] = slot_bytes[hit][wi*8 + k];
			pending_results.push_back(mk(id, STAT_WORD, n, wi, w, wi + 1 == nw));
		end
	endtask

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50)
			return 0;
		if (p < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	task automatic drive_frame(input logic [ID_W-1:0] id, input logic [LEN_W-1:0] len,
		input logic [DATA_W-1:0] data);
		int gap;
		can_id <= id;
		frame_length <= len;
		frame_bytes <= data;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		frames_sent++;
		if ($urandom_range(0, 3) != 0) begin
			gap = gap_len();
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic send_frame(input logic [ID_W-1:0] id, input logic [LEN_W-1:0] len,
		input logic [DATA_W-1:0] data);
		reassemble_frame(id, len, data);
		drive_frame(id, len, data);
	endtask

	// output side: random stall bursts, compare at accept
	always @(posedge clk) begin
		if (arst_n) begin
			cycles <= cycles + 1;
			if (out_valid && !out_stall) begin
				results_seen++;
				if (pending_results.size() == 0) begin
					$error("unexpected result id=%h status=%0d", msg_id, status);
					errors++;
				end else begin
					result_t e;
					e = pending_results.pop_front();
					if (e.stat != STAT_WORD)
						drops_seen++;
					if (msg_id !== e.id) begin
						$error("msg_id exp %h got %h", e.id, msg_id); errors++;
					end
					if (status !== e.stat) begin
						$error("status exp %0d got %0d", e.stat, status); errors++;
					end
					if (message_length !== e.mlen) begin
						$error("message_length exp %0d got %0d", e.mlen, message_length);
						errors++;
					end
					if (word_index !== e.widx) begin
						$error("word_index exp %0d got %0d", e.widx, word_index); errors++;
					end
					if (message_word !== e.word) begin
						$error("message_word exp %h got %h", e.word, message_word); errors++;
					end
					if (last_word !== e.last) begin
						$error("last_word exp %0d got %0d", e.last, last_word); errors++;
					end
				end
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left <= stall_left - 1;
			end else if ($urandom_range(0, 99) < 25) begin
				out_stall <= 1'b1;
				stall_left <= gap_len();
			end else begin
				out_stall <= 1'b0;
			end
			if (cycles > CYCLE_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	frame_row_t dir_rows[$];

	function automatic frame_row_t row(logic [ID_W-1:0] id, logic [LEN_W-1:0] len,
		logic [DATA_W-1:0] data, bit fixed, result_t res);
		frame_row_t r;
		r.id = id; r.len = len; r.data = data; r.fixed = fixed; r.res = res;
		return r;
	endfunction

	task automatic build_directed();
		result_t nr;
		nr = '0;
		// zero length ignored
		dir_rows.push_back(row(29'h1fffffff, 4'd0, 64'h0, 0, nr));
		// single frame, full payload, extreme id
		dir_rows.push_back(row(29'h1fffffff, 4'd8, 64'hffeeddccbbaa9900, 1,
			mk(29'h1fffffff, STAT_WORD, 7, 0, 64'h00ffeeddccbbaa99, 1)));
		// id 0 is an ordinary identifier, length above eight
		dir_rows.push_back(row(29'h0, 4'd15, 64'h0807060504030201, 0, nr));
		dir_rows.push_back(row(29'h0, 4'd8, 64'h0e0d0c0b0a090800, 0, nr));
		// empty message, length one
		dir_rows.push_back(row(29'h5, 4'd1, 64'h0, 0, nr));
		// interleaved messages, frame number 255 and order ignored
		dir_rows.push_back(row(29'h10, 4'd3, 64'hffffffffffff33ff, 0, nr));
		dir_rows.push_back(row(29'h11, 4'd2, 64'h0000000000005502, 0, nr));
		dir_rows.push_back(row(29'h10, 4'd4, 64'h0000000012345601, 0, nr));
		dir_rows.push_back(row(29'h11, 4'd2, 64'h0000000000006600, 0, nr));
		dir_rows.push_back(row(29'h10, 4'd2, 64'h0000000000007700, 0, nr));
		// fill the table, then one more id
		for (int i = 0; i < NSLOT; i++)
			dir_rows.push_back(row(ID_W'(32'h100 + i), 4'd8, 64'h1111111111111101, 0, nr));
		dir_rows.push_back(row(29'h1ff, 4'd8, 64'h01, 1, mk(29'h1ff, STAT_FULL, 0, 0, '0, 1)));
		for (int i = 0; i < NSLOT; i++)
			dir_rows.push_back(row(ID_W'(32'h100 + i), 4'd1, 64'h0, 0, nr));
	endtask

	// overflow: 37 frames of 7 bytes pass 256
	task automatic long_message(input logic [ID_W-1:0] id, input int nfr, input bit finish);
		logic [DATA_W-1:0] d;
		for (int i = 0; i < nfr; i++) begin
			d = {$urandom, $urandom};
			d[7:0] = (finish && i == nfr - 1) ? 8'd0 : 8'($urandom_range(1, 255));
			send_frame(id, 4'd8, d);
		end
	endtask

	initial begin
		logic [ID_W-1:0] ids[4];
		logic [DATA_W-1:0] d;
		int nfr, len, size0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		build_directed();
		foreach (dir_rows[i]) begin
			size0 = pending_results.size();
			reassemble_frame(dir_rows[i].id, dir_rows[i].len, dir_rows[i].data);
			if (dir_rows[i].fixed && (pending_results.size() != size0 + 1 ||
				pending_results[size0] !== dir_rows[i].res)) begin
				$error("table row %0d prediction mismatch", i);
				errors++;
			end
			drive_frame(dir_rows[i].id, dir_rows[i].len, dir_rows[i].data);
		end
		// exact 256-byte message closed by a five-byte frame: 36*7 + 4
		for (int i = 0; i < 36; i++)
			send_frame(29'h77, 4'd8, {$urandom, $urandom} | 64'h1);
		send_frame(29'h77, 4'd5, {$urandom, $urandom} & 64'hffffffffffffff00);
		long_message(29'h78, 37, 0);
		long_message(29'h78, 2, 1);
		// random multi-frame traffic over a small id pool
		while (frames_sent < 320) begin
			for (int i = 0; i < 4; i++)
				ids[i] = ($urandom_range(0, 3) == 0) ? ID_W'($urandom) :
					ID_W'($urandom_range(0, 11));
			if ($urandom_range(0, 29) == 0) begin
				long_message(ids[0], $urandom_range(30, 40), $urandom_range(0, 1));
				continue;
			end
			nfr = $urandom_range(1, 6);
			for (int i = 0; i < nfr; i++) begin
				d = {$urandom, $urandom};
				d[7:0] = (i == nfr - 1) ? 8'd0 : 8'($urandom_range(1, 255));
				if ($urandom_range(0, 9) == 0)
					d[7:0] = 8'($urandom);
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
				send_frame(ids[$urandom_range(0, 3)], len[LEN_W-1:0], d);
			end
		end
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		$display("frames sent %0d, results checked %0d (%0d drop reports)",
			frames_sent, results_seen, drops_seen);
		if (errors == 0 && pending_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule

### sim.f
rtl/cmr_pkg.sv
rtl/cmr_ctrl.sv
rtl/cmr_dpath.sv
rtl/can_multiframe_reassembler_unit.sv
tb/sv/can_multiframe_reassembler_unit_test.sv
